// ===== rtl/core/bile_pkg.sv =====
`timescale 1ns / 1ps
// Package for the bounded integer list engine: request and status codes,
// sequencer states and the request/result structs. No dependencies.
package bile_pkg;

    localparam int DEPTH_DEF = 1024;

    typedef enum logic [3:0] {
        K_GET      = 4'd0,
        K_SET      = 4'd1,
        K_APPEND   = 4'd2,
        K_POP      = 4'd3,
        K_INSERT   = 4'd4,
        K_REMOVE   = 4'd5,
        K_INDEX    = 4'd6,
        K_COUNT    = 4'd7,
        K_CONTAINS = 4'd8,
        K_CLEAR    = 4'd9,
        K_REVERSE  = 4'd10,
        K_SORT     = 4'd11,
        K_SUM      = 4'd12,
        K_ALL      = 4'd13,
        K_ANY      = 4'd14,
        K_LENGTH   = 4'd15
    } t_kind;

    typedef enum logic [2:0] {
        S_OK       = 3'd0,
        S_RANGE    = 3'd1,
        S_EMPTY    = 3'd2,
        S_NOTFOUND = 3'd3,
        S_FULL     = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START, ST_GET,
        ST_INS_RD, ST_INS_WR,
        ST_SCAN_RD, ST_SCAN_EX,
        ST_REM_RD, ST_REM_WR,
        ST_REV_A, ST_REV_B, ST_REV_C, ST_REV_D,
        ST_SRT_A, ST_SRT_B, ST_SRT_C, ST_SRT_D,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] position;
        logic signed [63:0] operand;
    } t_req;

    typedef struct packed {
        logic signed [63:0] value;
        t_status            status;
    } t_res;

endpackage

// ===== rtl/core/bile_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bile_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/bile_seq.sv =====
`timescale 1ns / 1ps
// Request sequencer of the list engine: walks the element RAM one access a
// step and keeps the element count. Depends on bile_pkg.
module bile_seq
    import bile_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_req          i_req,
    input  logic          i_take,
    output logic          o_idle,
    output logic          o_done,
    output t_res          o_res,
    output logic [CW-1:0] o_length,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [63:0]   o_wdata,
    output logic [AW-1:0] o_raddr,
    input  logic [63:0]   i_rdata
);
    t_state        r_state, n_state;
    t_req          r_req, n_req;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [63:0]   r_acc, n_acc;
    logic [63:0]   r_tmp, n_tmp;
    t_status       r_status, n_status;

    logic signed [33:0] pos_adj;
    logic [33:0]        cnt_ext;
    logic               pos_ok;
    logic [CW-1:0]      ins_slot;
    logic               hit;

    // resolve a negative position against the current length
    always_comb begin
        cnt_ext = {{(34 - CW){1'b0}}, r_count};
        pos_adj = {{2{r_req.position[31]}}, r_req.position}
                  + (r_req.position[31] ? $signed(cnt_ext) : 34'sd0);
        pos_ok  = !pos_adj[33] && (pos_adj < $signed(cnt_ext));
        if (pos_adj[33]) begin
            ins_slot = '0;
        end else if (pos_adj > $signed(cnt_ext)) begin
            ins_slot = r_count;
        end else begin
            ins_slot = pos_adj[CW-1:0];
        end
        hit = (i_rdata == r_req.operand);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_req    <= n_req;
        r_i      <= n_i;
        r_j      <= n_j;
        r_acc    <= n_acc;
        r_tmp    <= n_tmp;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_count  = r_count;
        n_i      = r_i;
        n_j      = r_j;
        n_acc    = r_acc;
        n_tmp    = r_tmp;
        n_status = r_status;
        o_we     = 1'b0;
        o_waddr  = '0;
        o_wdata  = r_req.operand;
        o_raddr  = '0;
        o_idle   = 1'b0;
        o_done   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_req   = i_req;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_acc    = '0;
                n_status = S_OK;
                n_i      = '0;
                n_state  = ST_DONE;
                case (r_req.kind)
                    K_GET: begin
                        if (pos_ok) begin
                            o_raddr = pos_adj[AW-1:0];
                            n_state = ST_GET;
                        end else begin
                            n_status = S_RANGE;
                        end
                    end
                    K_SET: begin
                        if (pos_ok) begin
                            o_we    = 1'b1;
                            o_waddr = pos_adj[AW-1:0];
                        end else begin
                            n_status = S_RANGE;
                        end
                    end
                    K_APPEND: begin
                        if (r_count >= CW'(DEPTH)) begin
                            n_status = S_FULL;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = r_count[AW-1:0];
                            n_count = r_count + 1'b1;
                        end
                    end
                    K_POP: begin
                        if (r_count == '0) begin
                            n_status = S_EMPTY;
                        end else begin
                            o_raddr = AW'(r_count - 1'b1);
                            n_count = r_count - 1'b1;
                            n_state = ST_GET;
                        end
                    end
                    K_INSERT: begin
                        if (r_count >= CW'(DEPTH)) begin
                            n_status = S_FULL;
                        end else begin
                            n_i     = r_count;
                            n_j     = ins_slot;
                            n_state = ST_INS_RD;
                        end
                    end
                    K_REMOVE, K_INDEX: begin
                        n_status = S_NOTFOUND;
                        n_state  = ST_SCAN_RD;
                    end
                    K_COUNT, K_CONTAINS, K_ANY: begin
                        n_state = ST_SCAN_RD;
                    end
                    K_SUM: begin
                        n_acc   = r_req.operand;
                        n_state = ST_SCAN_RD;
                    end
                    K_ALL: begin
                        n_acc   = 64'd1;
                        n_state = ST_SCAN_RD;
                    end
                    K_CLEAR: begin
                        n_count = '0;
                    end
                    K_REVERSE: begin
                        if (r_count > CW'(1)) begin
                            n_j     = r_count - 1'b1;
                            n_state = ST_REV_A;
                        end
                    end
                    K_SORT: begin
                        n_i     = CW'(1);
                        n_state = ST_SRT_A;
                    end
                    default: begin
                        n_acc = 64'(r_count);
                    end
                endcase
            end
            ST_GET: begin
                n_acc   = i_rdata;
                n_state = ST_DONE;
            end
            // insert: shift the tail up one slot, then drop the word in
            ST_INS_RD: begin
                if (r_i == r_j) begin
                    o_we    = 1'b1;
                    o_waddr = r_j[AW-1:0];
                    n_count = r_count + 1'b1;
                    n_state = ST_DONE;
                end else begin
                    o_raddr = AW'(r_i - 1'b1);
                    n_state = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                o_we    = 1'b1;
                o_waddr = r_i[AW-1:0];
                o_wdata = i_rdata;
                n_i     = r_i - 1'b1;
                n_state = ST_INS_RD;
            end
            // linear scan for search, count, sum, all, any and remove
            ST_SCAN_RD: begin
                if (r_i == r_count) begin
                    n_state = ST_DONE;
                end else begin
                    o_raddr = r_i[AW-1:0];
                    n_state = ST_SCAN_EX;
                end
            end
            ST_SCAN_EX: begin
                n_i     = r_i + 1'b1;
                n_state = ST_SCAN_RD;
                case (r_req.kind)
                    K_REMOVE: begin
                        if (hit) begin
                            n_status = S_OK;
                            n_j      = r_i;
                            n_state  = ST_REM_RD;
                        end
                    end
                    K_INDEX: begin
                        if (hit) begin
                            n_status = S_OK;
                            n_acc    = 64'(r_i);
                            n_state  = ST_DONE;
                        end
                    end
                    K_COUNT: begin
                        n_acc = r_acc + 64'(hit);
                    end
                    K_CONTAINS: begin
                        if (hit) begin
                            n_acc   = 64'd1;
                            n_state = ST_DONE;
                        end
                    end
                    K_SUM: begin
                        n_acc = r_acc + i_rdata;
                    end
                    K_ALL: begin
                        if (i_rdata == '0) begin
                            n_acc   = '0;
                            n_state = ST_DONE;
                        end
                    end
                    K_ANY: begin
                        if (i_rdata != '0) begin
                            n_acc   = 64'd1;
                            n_state = ST_DONE;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            // remove: shift the tail down over the match
            ST_REM_RD: begin
                if (r_j + 1'b1 == r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = ST_DONE;
                end else begin
                    o_raddr = AW'(r_j + 1'b1);
                    n_state = ST_REM_WR;
                end
            end
            ST_REM_WR: begin
                o_we    = 1'b1;
                o_waddr = r_j[AW-1:0];
                o_wdata = i_rdata;
                n_j     = r_j + 1'b1;
                n_state = ST_REM_RD;
            end
            // reverse: swap the two ends and move inward
            ST_REV_A: begin
                if (r_i < r_j) begin
                    o_raddr = r_i[AW-1:0];
                    n_state = ST_REV_B;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_REV_B: begin
                n_tmp   = i_rdata;
                o_raddr = r_j[AW-1:0];
                n_state = ST_REV_C;
            end
            ST_REV_C: begin
                o_we    = 1'b1;
                o_waddr = r_i[AW-1:0];
                o_wdata = i_rdata;
                n_state = ST_REV_D;
            end
            ST_REV_D: begin
                o_we    = 1'b1;
                o_waddr = r_j[AW-1:0];
                o_wdata = r_tmp;
                n_i     = r_i + 1'b1;
                n_j     = r_j - 1'b1;
                n_state = ST_REV_A;
            end
            // insertion sort, ascending signed
            ST_SRT_A: begin
                if (r_i >= r_count) begin
                    n_state = ST_DONE;
                end else begin
                    o_raddr = r_i[AW-1:0];
                    n_state = ST_SRT_B;
                end
            end
            ST_SRT_B: begin
                n_tmp   = i_rdata;
                n_j     = r_i;
                n_state = ST_SRT_C;
            end
            ST_SRT_C: begin
                if (r_j == '0) begin
                    o_we    = 1'b1;
                    o_waddr = '0;
                    o_wdata = r_tmp;
                    n_i     = r_i + 1'b1;
                    n_state = ST_SRT_A;
                end else begin
                    o_raddr = AW'(r_j - 1'b1);
                    n_state = ST_SRT_D;
                end
            end
            ST_SRT_D: begin
                o_we    = 1'b1;
                o_waddr = r_j[AW-1:0];
                if ($signed(i_rdata) > $signed(r_tmp)) begin
                    o_wdata = i_rdata;
                    n_j     = r_j - 1'b1;
                    n_state = ST_SRT_C;
                end else begin
                    o_wdata = r_tmp;
                    n_i     = r_i + 1'b1;
                    n_state = ST_SRT_A;
                end
            end
            ST_DONE: begin
                o_done = 1'b1;
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res.value  = r_acc;
    assign o_res.status = r_status;
    assign o_length     = r_count;
endmodule

// ===== rtl/core/bounded_integer_list_engine_core.sv =====
`timescale 1ns / 1ps
// Top level of the bounded integer list engine: stream ports, element RAM,
// sequencer and output register. Depends on bile_pkg, bile_ram, bile_seq.
//
// One request is worked at a time; each gives exactly one result. Element
// words sit in a DEPTH x 64 RAM with a registered read, and the sequencer
// makes one RAM access per step, so cost is set by that port: get, pop,
// length, set, append and clear do not depend on the list length; search,
// count, contains, sum, all and any grow with the elements scanned; insert
// and remove with the elements moved; reverse with the swapped pairs; sort
// is insertion sort and grows with the elements and the element moves. A new
// request is taken once the previous result sits in the output register.
module bounded_integer_list_engine_core
    import bile_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int OW    = ((64 + CW + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [95:0]   i_s_tdata,   // position[31:0], operand[95:32]
    input  logic [3:0]    i_s_tuser,   // kind[3:0]
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [OW-1:0] o_m_tdata,   // result_value[63:0], length_after, zero fill
    output logic [2:0]    o_m_tuser    // status[2:0]
);
    t_req          req;
    t_res          seq_res;
    logic [CW-1:0] seq_len;
    logic          seq_idle, seq_done, take;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;

    logic          r_valid;
    t_res          r_res;
    logic [CW-1:0] r_len;

    assign req.kind     = t_kind'(i_s_tuser);
    assign req.position = i_s_tdata[31:0];
    assign req.operand  = i_s_tdata[95:32];

    // accept a new transaction only while the sequencer is idle
    assign o_s_tready = seq_idle;
    // move a finished result into the output register when it is free
    assign take = seq_done && (!r_valid || i_m_tready);

    bile_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bile_seq #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_s_tvalid && o_s_tready),
        .i_req    (req),
        .i_take   (take),
        .o_idle   (seq_idle),
        .o_done   (seq_done),
        .o_res    (seq_res),
        .o_length (seq_len),
        .o_we     (ram_we),
        .o_waddr  (ram_waddr),
        .o_wdata  (ram_wdata),
        .o_raddr  (ram_raddr),
        .i_rdata  (ram_rdata)
    );

    // output register: hold until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
        if (take) begin
            r_res <= seq_res;
            r_len <= seq_len;
        end
    end

    always_comb begin
        o_m_tdata          = '0;
        o_m_tdata[63:0]    = r_res.value;
        o_m_tdata[64 +: CW] = r_len;
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_res.status;
endmodule

// ===== rtl/core/bile_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the list engine core, bound to the top level.
// Depends on bile_pkg and bounded_integer_list_engine_core.
module bile_checker
    import bile_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int OW    = ((64 + CW + 7) / 8) * 8
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_s_tvalid,
    input logic          o_s_tready,
    input logic [95:0]   i_s_tdata,
    input logic [3:0]    i_s_tuser,
    input logic          o_m_tvalid,
    input logic          i_m_tready,
    input logic [OW-1:0] o_m_tdata,
    input logic [2:0]    o_m_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[64 +: CW] <= CW'(DEPTH))
        else $error("length beyond depth");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == S_FULL |-> o_m_tdata[64 +: CW] == CW'(DEPTH))
        else $error("full reported below depth");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == S_EMPTY
        |-> o_m_tdata[64 +: CW] == '0 && o_m_tdata[63:0] == '0)
        else $error("empty pop with nonzero length or value");
endmodule

bind bounded_integer_list_engine_core bile_checker #(
    .DEPTH(DEPTH), .AW(AW), .CW(CW), .OW(OW)
) u_bile_checker (.*);

// ===== tb/sv/bile_list_checker.sv =====
`timescale 1ns / 1ps
// Checker for the bounded integer list engine: watches both stream channels,
// keeps a shadow list to predict each result and compares in order.
// Depends on bile_pkg.
module bile_list_checker
    import bile_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int OW    = 80
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tready,
    input  logic [95:0]   i_s_tdata,
    input  logic [3:0]    i_s_tuser,
    input  logic          i_m_tvalid,
    input  logic          i_m_tready,
    input  logic [OW-1:0] i_m_tdata,
    input  logic [2:0]    i_m_tuser,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_list_len
);

    typedef struct {
        logic [63:0] value;
        t_status     status;
        logic [10:0] len;
    } t_outcome;

    logic [63:0] shadow_list [DEPTH];
    int          shadow_len;
    t_outcome    outcome_q [$];

    assign o_pending  = outcome_q.size();
    assign o_list_len = shadow_len;

    initial begin
        o_fail_count = 0;
        shadow_len   = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    // Apply one request to the shadow list and return its outcome.
    function automatic t_outcome apply_request(t_kind kind, logic signed [31:0] pos,
                                               logic [63:0] opnd);
        t_outcome    r;
        longint      p;
        int          n;
        int          slot;
        logic [63:0] w;
        int          j;
        r.value  = '0;
        r.status = S_OK;
        n = shadow_len;
        p = pos;
        case (kind)
            K_GET, K_SET: begin
                if (p < 0) p += n;
                if (p < 0 || p >= n) begin
                    r.status = S_RANGE;
                end else if (kind == K_GET) begin
                    r.value = shadow_list[p];
                end else begin
                    shadow_list[p] = opnd;
                end
            end
            K_APPEND: begin
                if (n >= DEPTH) r.status = S_FULL;
                else begin
                    shadow_list[n] = opnd;
                    shadow_len = n + 1;
                end
            end
            K_POP: begin
                if (n == 0) r.status = S_EMPTY;
                else begin
                    shadow_len = n - 1;
                    r.value = shadow_list[n-1];
                end
            end
            K_INSERT: begin
                if (n >= DEPTH) r.status = S_FULL;
                else begin
                    // clamp into 0..length after wrapping negatives
                    if (p < 0) p += n;
                    if (p < 0) p = 0;
                    if (p > n) p = n;
                    slot = p;
                    for (int i = n; i > slot; i--) shadow_list[i] = shadow_list[i-1];
                    shadow_list[slot] = opnd;
                    shadow_len = n + 1;
                end
            end
            K_REMOVE: begin
                r.status = S_NOTFOUND;
                for (int i = 0; i < n; i++) begin
                    if (shadow_list[i] == opnd) begin
                        for (int k = i; k + 1 < n; k++) shadow_list[k] = shadow_list[k+1];
                        shadow_len = n - 1;
                        r.status = S_OK;
                        break;
                    end
                end
            end
            K_INDEX: begin
                r.status = S_NOTFOUND;
                for (int i = 0; i < n; i++) begin
                    if (shadow_list[i] == opnd) begin
                        r.value = i;
                        r.status = S_OK;
                        break;
                    end
                end
            end
            K_COUNT: begin
                for (int i = 0; i < n; i++) if (shadow_list[i] == opnd) r.value++;
            end
            K_CONTAINS: begin
                for (int i = 0; i < n; i++) if (shadow_list[i] == opnd) r.value = 1;
            end
            K_CLEAR: shadow_len = 0;
            K_REVERSE: begin
                for (int i = 0; i < n / 2; i++) begin
                    w = shadow_list[i];
                    shadow_list[i] = shadow_list[n-1-i];
                    shadow_list[n-1-i] = w;
                end
            end
            K_SORT: begin
                for (int i = 1; i < n; i++) begin
                    w = shadow_list[i];
                    j = i;
                    while (j > 0 && $signed(shadow_list[j-1]) > $signed(w)) begin
                        shadow_list[j] = shadow_list[j-1];
                        j--;
                    end
                    shadow_list[j] = w;
                end
            end
            K_SUM: begin
                r.value = opnd;
                for (int i = 0; i < n; i++) r.value += shadow_list[i];
            end
            K_ALL: begin
                r.value = 1;
                for (int i = 0; i < n; i++) if (shadow_list[i] == 0) r.value = 0;
            end
            K_ANY: begin
                for (int i = 0; i < n; i++) if (shadow_list[i] != 0) r.value = 1;
            end
            default: r.value = n;
        endcase
        r.len = shadow_len[10:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("unexpected result", i_m_tdata[63:0], '0);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_m_tdata[63:0] !== want.value)
                        report_mismatch("result_value", i_m_tdata[63:0], want.value);
                    if (i_m_tuser !== want.status)
                        report_mismatch("status", i_m_tuser, want.status);
                    if (i_m_tdata[74:64] !== want.len)
                        report_mismatch("length_after", i_m_tdata[74:64], want.len);
                    if (i_m_tdata[OW-1:75] !== '0)
                        report_mismatch("zero fill", i_m_tdata[OW-1:75], '0);
                end
            end
            if (i_s_tvalid && i_s_tready)
                outcome_q.push_back(apply_request(t_kind'(i_s_tuser), i_s_tdata[31:0],
                                                  i_s_tdata[95:32]));
        end
    end

endmodule

// ===== tb/sv/bounded_integer_list_engine_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the bounded integer list engine: clock, reset, request
// stimulus, result back-pressure and verdict. Depends on bile_pkg,
// bile_list_checker and bounded_integer_list_engine_core.
module bounded_integer_list_engine_core_tb;
    import bile_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int OW         = 80;
    localparam int RAND_ITEMS = 580;
    localparam int QUIET_TAIL = 80;
    localparam int STALL_MAX  = 200000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_s_tvalid;
    logic          o_s_tready;
    logic [95:0]   i_s_tdata;   // position[31:0], operand[95:32]
    logic [3:0]    i_s_tuser;   // kind[3:0]
    logic          o_m_tvalid;
    logic          i_m_tready;
    logic [OW-1:0] o_m_tdata;   // result_value[63:0], length_after[74:64], zero fill
    logic [2:0]    o_m_tuser;   // status[2:0]

    int fail_count;
    int pending;
    int list_len;
    int stall_cycles;
    bit quiet;

    logic [63:0] value_pool [8];

    bounded_integer_list_engine_core #(.DEPTH(DEPTH)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    bile_list_checker #(.DEPTH(DEPTH), .OW(OW)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_list_len  (list_len)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Result back-pressure: alternate ready and stall bursts until the quiet tail.
    always @(negedge i_clk) begin
        int burst;
        if (quiet || !i_rst_n) begin
            i_m_tready <= 1'b1;
            burst = 0;
        end else if (burst > 0) begin
            burst--;
        end else if ($urandom_range(0, 2) == 0) begin
            i_m_tready <= 1'b0;
            burst = $urandom_range(1, 15) - 1;
        end else begin
            i_m_tready <= 1'b1;
            burst = $urandom_range(1, 30) - 1;
        end
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    // Drive one request at the falling edge and hold it until accepted.
    task automatic send_request(input t_kind kind, input logic [31:0] pos,
                                input logic [63:0] opnd);
        bit taken;
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser  = kind;
        i_s_tdata  = {opnd, pos};
        taken = 1'b0;
        while (!taken) begin
            #0.5;
            taken = o_s_tready;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b0;
    endtask

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 3))
            0:       return {$urandom, $urandom};
            default: return value_pool[$urandom_range(0, 7)];
        endcase
    endfunction

    function automatic logic [31:0] pick_position(int n);
        if ($urandom_range(0, 4) == 0) return $urandom;
        return $urandom_range(0, 2 * n + 6) - (n + 3);
    endfunction

    // Random kind, biased to keep the list short so scans and sorts stay cheap.
    function automatic t_kind pick_kind(int n);
        t_kind k;
        k = t_kind'($urandom_range(0, 15));
        if (n > 48 && (k == K_APPEND || k == K_INSERT) && $urandom_range(0, 1))
            k = K_POP;
        if (k == K_SORT && n > 64) k = K_REVERSE;
        if (k == K_CLEAR && $urandom_range(0, 3) != 0) k = K_APPEND;
        return k;
    endfunction

    initial begin
        int limit;
        value_pool = '{64'h0, 64'h1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                       64'hFFFF_FFFF_FFFF_FFFF, 64'h5, 64'h2A, 64'hDEAD_BEEF_0000_1234};
        quiet      = 1'b1;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        i_m_tready = 1'b1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        quiet   = 1'b0;

        // Empty-list corner cases.
        send_request(K_LENGTH, 32'd0, 64'd0);
        send_request(K_POP, 32'd0, 64'd0);
        send_request(K_GET, 32'd0, 64'd0);
        send_request(K_SET, 32'hFFFF_FFFF, 64'd9);
        send_request(K_ALL, 32'd0, 64'd0);
        send_request(K_ANY, 32'd0, 64'd0);
        // Extremes, clamped inserts and negative indexing.
        send_request(K_APPEND, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(K_APPEND, 32'd0, 64'h8000_0000_0000_0000);
        send_request(K_APPEND, 32'd0, 64'd0);
        send_request(K_INSERT, 32'h8000_0000, 64'd5);
        send_request(K_INSERT, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(K_INSERT, 32'hFFFF_FFFF, 64'd5);
        send_request(K_GET, 32'hFFFF_FFFF, 64'd0);
        send_request(K_GET, -32'sd6, 64'd0);
        send_request(K_GET, -32'sd7, 64'd0);
        send_request(K_GET, 32'd6, 64'd0);
        send_request(K_SET, 32'hFFFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(K_INDEX, 32'd0, 64'd5);
        send_request(K_INDEX, 32'd0, 64'd77);
        send_request(K_REMOVE, 32'd0, 64'd77);
        send_request(K_COUNT, 32'd0, 64'd5);
        send_request(K_REMOVE, 32'd0, 64'd5);
        send_request(K_CONTAINS, 32'd0, 64'd5);
        send_request(K_SUM, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(K_ALL, 32'd0, 64'd0);
        send_request(K_ANY, 32'd0, 64'd0);
        send_request(K_REVERSE, 32'd0, 64'd0);
        send_request(K_SORT, 32'd0, 64'd0);
        send_request(K_CLEAR, 32'd0, 64'd0);

        // Fill the store to capacity, then probe the full condition.
        for (int i = 0; i < DEPTH; i++)
            send_request(K_APPEND, 32'd0, {$urandom, $urandom});
        send_request(K_APPEND, 32'd0, 64'd1);
        send_request(K_INSERT, 32'd3, 64'd1);
        send_request(K_GET, 32'd1023, 64'd0);
        send_request(K_GET, 32'd1024, 64'd0);
        send_request(K_SUM, 32'd0, 64'd0);
        send_request(K_REVERSE, 32'd0, 64'd0);
        send_request(K_POP, 32'd0, 64'd0);
        send_request(K_INSERT, 32'd0, 64'd3);
        send_request(K_CLEAR, 32'd0, 64'd0);

        // Random traffic; drop idling for the tail.
        for (int i = 0; i < RAND_ITEMS; i++) begin
            t_kind k;
            if (i == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
            k = pick_kind(list_len);
            send_request(k, pick_position(list_len), pick_operand());
        end

        quiet = 1'b1;
        limit = 0;
        while (pending != 0 && limit < STALL_MAX) begin
            @(posedge i_clk);
            limit++;
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
